@@ sv/lazy_range_add_sum_tree_core_assert.svh @@
// Assertion macros for the lazy range add / range sum tree core.
// Included by the top level; needs nothing else.
`ifndef LAZY_RANGE_ADD_SUM_TREE_CORE_ASSERT_SVH
`define LAZY_RANGE_ADD_SUM_TREE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRAST_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lrast: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRAST_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lrast: next-cycle check failed");

`endif

@@ sv/lrast_pkg.sv @@
// Shared constants for the lazy range add / range sum tree core.
// No dependencies.
package lrast_pkg;

    localparam int ELEMENT_COUNT_DEF = 1024;
    localparam int IDX_W             = 10;
    localparam int DATA_W            = 32;

    // Command codes carried in the command field of an item.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

@@ sv/lrast_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one range add or range sum item.
// Depends on lrast_pkg.
interface lrast_cmd_if;

    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [lrast_pkg::IDX_W-1:0]       first_index;
    logic [lrast_pkg::IDX_W-1:0]       last_index;
    logic signed [lrast_pkg::DATA_W-1:0] add_value;

    modport source (output valid, command, first_index, last_index, add_value,
                    input ready);
    modport sink   (input valid, command, first_index, last_index, add_value,
                    output ready);

endinterface

@@ sv/lrast_res_if.sv @@
// Result channel: valid/ready handshake carrying one range sum result item.
// Depends on lrast_pkg.
interface lrast_res_if;

    logic                                valid;
    logic                                ready;
    logic signed [lrast_pkg::DATA_W-1:0] range_sum;
    logic                                range_rejected;

    modport source (output valid, range_sum, range_rejected, input ready);
    modport sink   (input valid, range_sum, range_rejected, output ready);

endinterface

@@ sv/lazy_range_add_sum_tree_core.sv @@
// Lazy segment tree with range add and range sum over ELEMENT_COUNT signed elements.
// Depends on lrast_pkg, lrast_cmd_if, lrast_res_if, lrast_node_ram and the assert header.
//
// Usage: items enter on the cmd channel (valid/ready). Each item either adds add_value
// to every element of [first_index, last_index] (command 0) or asks for the wrapped
// 32-bit sum over that range (command 1). Exactly one result item leaves on the res
// channel per command item: the sum for a query, zero for an add, and range_rejected
// set with a zero sum when the range is reversed or reaches past ELEMENT_COUNT-1.
// After reset the block sweeps the node store to zero, one word per cycle, covering
// all 4*ELEMENT_COUNT+5 words; cmd.ready stays low during the sweep.
// One item is worked on at a time. The walk visits about four nodes per tree level,
// and each visit goes through the node store, with its one write port and one read
// port, and the one 32x11 multiplier. A rejected item skips the walk: the block goes
// from S_IDLE straight to S_DONE, loads its result into the output register and then
// returns to S_IDLE to take the next item.
// The result sits in an output register; while the receiver stalls the block still
// takes the next item and works on it, and only holds at the hand-off of its result.
module lazy_range_add_sum_tree_core #(
    parameter int ELEMENT_COUNT = lrast_pkg::ELEMENT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lrast_cmd_if.sink   cmd,
    lrast_res_if.source res
);

    localparam int DATA_W      = lrast_pkg::DATA_W;
    localparam int IDX_W       = lrast_pkg::IDX_W;
    localparam int TREE_SLOTS  = 4 * ELEMENT_COUNT + 5;
    localparam int NODE_W      = $clog2(TREE_SLOTS);
    localparam int POS_W       = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam int LEN_W       = $clog2(ELEMENT_COUNT + 1);
    localparam int STACK_DEPTH = $clog2(ELEMENT_COUNT) + 1;
    localparam int STK_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 2 * DATA_W;

    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(ELEMENT_COUNT - 1);
    localparam logic [31:0]       COUNT_32  = 32'(ELEMENT_COUNT);
    localparam logic [NODE_W-1:0] LAST_SLOT = NODE_W'(TREE_SLOTS - 1);
    localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_VISIT  = 4'd2;
    localparam logic [3:0] S_NODE   = 4'd3;
    localparam logic [3:0] S_HD_L   = 4'd4;
    localparam logic [3:0] S_HD_R   = 4'd5;
    localparam logic [3:0] S_GATH_L = 4'd6;
    localparam logic [3:0] S_GATH_R = 4'd7;
    localparam logic [3:0] S_POP    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    // Progress of a node frame on the walk stack.
    localparam logic [1:0] PH_ENTER      = 2'd0;
    localparam logic [1:0] PH_LEFT_DONE  = 2'd1;
    localparam logic [1:0] PH_RIGHT_DONE = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic [1:0]        ph;
    } frame_t;

    logic [3:0]        state_reg, state_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic              query_reg, query_next;
    logic [IDX_W-1:0]  a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [DATA_W-1:0] v_reg, v_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              rej_reg, rej_next;
    frame_t            cur_reg, cur_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    frame_t            stack_reg [STACK_DEPTH];
    logic [DATA_W-1:0] mul_reg;
    logic [DATA_W-1:0] pend_reg, pend_next;
    logic [DATA_W-1:0] suml_reg, suml_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_sum_reg, out_sum_next;
    logic              out_rej_reg, out_rej_next;

    logic              push;
    frame_t            push_frame;
    logic [SP_W-1:0]   sp_dec;
    logic [DATA_W-1:0] mul_a;
    logic [LEN_W-1:0]  mul_b;

    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [NODE_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [DATA_W-1:0] rd_pend;
    logic [DATA_W-1:0] rd_sum;

    logic [POS_W-1:0]  mid;
    logic [NODE_W-1:0] left_n;
    logic [NODE_W-1:0] right_n;
    logic [LEN_W-1:0]  len_cur;
    logic [LEN_W-1:0]  len_l;
    logic [LEN_W-1:0]  len_r;
    logic              disjoint;
    logic              covered;
    logic              bad_range;

    lrast_node_ram #(
        .DEPTH  (TREE_SLOTS),
        .ADDR_W (NODE_W),
        .WORD_W (WORD_W)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_pend = ram_rdata[WORD_W-1:DATA_W];
    assign rd_sum  = ram_rdata[DATA_W-1:0];

    // Geometry of the node under the cursor.
    assign mid     = cur_reg.lo + ((cur_reg.hi - cur_reg.lo) >> 1);
    assign left_n  = cur_reg.node << 1;
    assign right_n = left_n | NODE_W'(1);
    assign len_cur = LEN_W'(cur_reg.hi) - LEN_W'(cur_reg.lo) + LEN_W'(1);
    assign len_l   = LEN_W'(mid) - LEN_W'(cur_reg.lo) + LEN_W'(1);
    assign len_r   = LEN_W'(cur_reg.hi) - LEN_W'(mid);
    assign disjoint = (32'(cur_reg.lo) > 32'(b_reg)) || (32'(cur_reg.hi) < 32'(a_reg));
    assign covered  = (32'(cur_reg.lo) >= 32'(a_reg)) && (32'(cur_reg.hi) <= 32'(b_reg));
    assign bad_range = (cmd.first_index > cmd.last_index)
                    || (32'(cmd.last_index) >= COUNT_32);
    assign sp_dec   = sp_reg - SP_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        query_next     = query_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        rej_next       = rej_reg;
        cur_next       = cur_reg;
        sp_next        = sp_reg;
        pend_next      = pend_reg;
        suml_next      = suml_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        out_rej_next   = out_rej_reg;
        push           = 1'b0;
        push_frame     = cur_reg;
        mul_a          = v_reg;
        mul_b          = len_cur;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg.node;
        ram_wdata      = '0;
        ram_raddr      = cur_reg.node;
        cmd.ready      = 1'b0;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    query_next = (cmd.command == lrast_pkg::CMD_QUERY);
                    a_next     = cmd.first_index;
                    b_next     = cmd.last_index;
                    v_next     = cmd.add_value;
                    acc_next   = '0;
                    rej_next   = bad_range;
                    sp_next    = '0;
                    cur_next   = '{node: ROOT_NODE, lo: '0, hi: LAST_POS, ph: PH_ENTER};
                    state_next = bad_range ? S_DONE : S_VISIT;
                end
            end
            S_VISIT:
            begin
                case (cur_reg.ph)
                    PH_ENTER:
                    begin
                        // Read the node now; v * length lands in mul_reg alongside it.
                        state_next = disjoint ? S_POP : S_NODE;
                    end
                    PH_LEFT_DONE:
                    begin
                        push          = 1'b1;
                        push_frame.ph = PH_RIGHT_DONE;
                        cur_next      = '{node: right_n, lo: mid + POS_W'(1),
                                          hi: cur_reg.hi, ph: PH_ENTER};
                    end
                    PH_RIGHT_DONE:
                    begin
                        if (query_reg)
                        begin
                            state_next = S_POP;
                        end
                        else
                        begin
                            ram_raddr  = left_n;
                            state_next = S_GATH_L;
                        end
                    end
                    default:
                    begin
                        state_next = S_POP;
                    end
                endcase
            end
            S_NODE:
            begin
                if (covered)
                begin
                    if (query_reg)
                    begin
                        acc_next = acc_reg + rd_sum;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_pend + v_reg, rd_sum + mul_reg};
                    end
                    state_next = S_POP;
                end
                else
                begin
                    pend_next = rd_pend;
                    if (rd_pend != '0)
                    begin
                        // Hand the pending add down to both children first.
                        ram_we     = 1'b1;
                        ram_wdata  = {{DATA_W{1'b0}}, rd_sum};
                        ram_raddr  = left_n;
                        mul_a      = rd_pend;
                        mul_b      = len_l;
                        state_next = S_HD_L;
                    end
                    else
                    begin
                        push          = 1'b1;
                        push_frame.ph = PH_LEFT_DONE;
                        cur_next      = '{node: left_n, lo: cur_reg.lo, hi: mid, ph: PH_ENTER};
                        state_next    = S_VISIT;
                    end
                end
            end
            S_HD_L:
            begin
                ram_we     = 1'b1;
                ram_waddr  = left_n;
                ram_wdata  = {rd_pend + pend_reg, rd_sum + mul_reg};
                ram_raddr  = right_n;
                mul_a      = pend_reg;
                mul_b      = len_r;
                state_next = S_HD_R;
            end
            S_HD_R:
            begin
                ram_we        = 1'b1;
                ram_waddr     = right_n;
                ram_wdata     = {rd_pend + pend_reg, rd_sum + mul_reg};
                push          = 1'b1;
                push_frame.ph = PH_LEFT_DONE;
                cur_next      = '{node: left_n, lo: cur_reg.lo, hi: mid, ph: PH_ENTER};
                state_next    = S_VISIT;
            end
            S_GATH_L:
            begin
                suml_next  = rd_sum;
                ram_raddr  = right_n;
                state_next = S_GATH_R;
            end
            S_GATH_R:
            begin
                // The node's pending add was cleared before its children were visited.
                ram_we     = 1'b1;
                ram_wdata  = {{DATA_W{1'b0}}, suml_reg + rd_sum};
                state_next = S_POP;
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = stack_reg[sp_dec[STK_W-1:0]];
                    sp_next    = sp_dec;
                    state_next = S_VISIT;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    out_rej_next   = rej_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg   <= query_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        v_reg       <= v_next;
        acc_reg     <= acc_next;
        rej_reg     <= rej_next;
        cur_reg     <= cur_next;
        pend_reg    <= pend_next;
        suml_reg    <= suml_next;
        out_sum_reg <= out_sum_next;
        out_rej_reg <= out_rej_next;
        mul_reg     <= 32'(mul_a * DATA_W'(mul_b));
        if (push)
        begin
            stack_reg[sp_reg[STK_W-1:0]] <= push_frame;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.range_sum      = out_sum_reg;
    assign res.range_rejected = out_rej_reg;

    `include "lazy_range_add_sum_tree_core_assert.svh"

    `LRAST_ASSERT_IMPLY(a_stack_bound, clk, rst_n, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `LRAST_ASSERT_IMPLY(a_no_take_in_sweep, clk, rst_n, state_reg == S_CLEAR, !cmd.ready)
    `LRAST_ASSERT_IMPLY(a_reject_zero, clk, rst_n, res.valid && res.range_rejected, res.range_sum == '0)
    `LRAST_ASSERT_NEXT(a_result_drains, clk, rst_n, res.valid && res.ready && state_reg != S_DONE, !res.valid)

endmodule

@@ sv/lrast_node_ram.sv @@
// Node store: one write port and one read port with registered read data.
// Each word holds a node's pending add above its node sum. No dependencies.
module lrast_node_ram #(
    parameter int DEPTH  = 4101,
    parameter int ADDR_W = 13,
    parameter int WORD_W = 64
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
